// ----- rtl/core/sbb_pkg.sv -----
`default_nettype none

package sbb_pkg;

  // Input item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;

  // Field widths fixed by the interface.
  localparam int CFG_DATA_W = 9;
  localparam int SAMPLE_W   = 8;
  localparam int VALUE_W    = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESP,
    ST_LINE,
    ST_PRE_RD,
    ST_PRE_ACC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_ADD_RD,
    ST_ADD_ACC,
    ST_SUB_RD,
    ST_SUB_ACC,
    ST_NEXT
  } state_t;

  typedef enum logic [1:0] {
    POS_PREFILL,
    POS_ADD,
    POS_SUB
  } pos_sel_t;

  typedef struct packed {
    logic     load_wr;
    logic     load_restart;
    logic     latch_frame;
    logic     read_issue;
    logic     out_load;
    logic     line_init;
    logic     pre_acc;
    logic     k_inc;
    logic     div_start;
    logic     div_store;
    logic     add_acc;
    logic     sub_acc;
    logic     next_pixel;
    logic     next_line;
    logic     next_pass;
    pos_sel_t pos_sel;
  } cmd_t;

  typedef struct packed {
    logic load_done;
    logic pre_last;
    logic div_done;
    logic add_ok;
    logic sub_ok;
    logic pix_last;
    logic line_last;
    logic vert_pass;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/separable_box_blur.sv -----
`default_nettype none

// Channel  Direction  Handshake                Payload
// req      in         req_valid / req_ready    kind, sample
// res      out        res_valid / res_ready    blurred_value, last
// cfg      in         cfg_wr_en (no wait)      cfg_index, cfg_data
//
// A load beat is taken in ST_IDLE. After a read beat the controller enters ST_RESP,
// which loads the output register, and no request beat is taken in that state. The
// beat that completes a frame starts the two passes, during which req_ready is low.
// A bit-serial divider normalizes each window (NUM_W = 16 + clog2(2*MAX_RADIUS+2),
// 23 at the defaults), and each line starts by prefilling the window sum.
// Synchronous reset clears control and config state; the frame stores need no clearing.
// A held result in the output register stalls further read beats, loads still go through.

module separable_box_blur #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 63
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_ready,
  input  wire logic                           kind,
  input  wire logic [sbb_pkg::SAMPLE_W-1:0]   sample,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output logic [sbb_pkg::VALUE_W-1:0]         blurred_value,
  output logic                                last,
  input  wire logic                           cfg_wr_en,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [sbb_pkg::CFG_DATA_W-1:0] cfg_data
);

  // The controller sequences loading, the two filter passes and read-out.
  // The datapath holds the three frame stores, the running window sum,
  // the line counters and the divider that normalizes each window.
  sbb_pkg::cmd_t    cmd;
  sbb_pkg::status_t status;

  sbb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .kind     (kind),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sbb_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .cmd          (cmd),
    .status       (status),
    .blurred_value(blurred_value),
    .last         (last)
  );

endmodule

`default_nettype wire

// ----- rtl/core/sbb_divider.sv -----
`default_nettype none

// Restoring radix-2 divider, one quotient bit per cycle.
module sbb_divider #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] count;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NUM_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, den_q});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

// ----- rtl/core/sbb_datapath.sv -----
`default_nettype none

module sbb_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 63
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [sbb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [sbb_pkg::SAMPLE_W-1:0] sample,
  input  wire sbb_pkg::cmd_t                cmd,
  output sbb_pkg::status_t                  status,
  output logic [sbb_pkg::VALUE_W-1:0]       blurred_value,
  output logic                              last
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W  = $clog2(DEPTH + 1);
  localparam int MAXD   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W  = $clog2(MAXD + 1);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int CNT_W  = $clog2(2 * MAX_RADIUS + 2);
  localparam int SUM_W  = sbb_pkg::VALUE_W + CNT_W;
  localparam int EXT_W  = ((DIM_W > RAD_W) ? DIM_W : RAD_W) + 1;
  localparam int PROD_W = 2 * DIM_W;
  localparam int VW     = sbb_pkg::VALUE_W;
  localparam int SW     = sbb_pkg::SAMPLE_W;

  // Configuration registers.
  logic [sbb_pkg::CFG_DATA_W-1:0] width_reg;
  logic [sbb_pkg::CFG_DATA_W-1:0] height_reg;
  logic [5:0]                     blur_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg   <= sbb_pkg::CFG_DATA_W'(256);
      height_reg  <= sbb_pkg::CFG_DATA_W'(256);
      blur_radius <= 6'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sbb_pkg::CFG_WIDTH:  width_reg   <= cfg_data;
        sbb_pkg::CFG_HEIGHT: height_reg  <= cfg_data;
        sbb_pkg::CFG_RADIUS: blur_radius <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Effective frame size and radius, clamped to the supported range.
  logic [DIM_W-1:0]  eff_w, eff_h;
  logic [RAD_W-1:0]  eff_r;
  logic [PROD_W-1:0] total_full;
  logic [POS_W-1:0]  total;

  always_comb begin
    if (width_reg == '0) begin
      eff_w = DIM_W'(1);
    end else if (32'(width_reg) > MAX_WIDTH) begin
      eff_w = DIM_W'(MAX_WIDTH);
    end else begin
      eff_w = DIM_W'(width_reg);
    end
    if (height_reg == '0) begin
      eff_h = DIM_W'(1);
    end else if (32'(height_reg) > MAX_HEIGHT) begin
      eff_h = DIM_W'(MAX_HEIGHT);
    end else begin
      eff_h = DIM_W'(height_reg);
    end
    if (32'(blur_radius) > MAX_RADIUS) begin
      eff_r = RAD_W'(MAX_RADIUS);
    end else begin
      eff_r = RAD_W'(blur_radius);
    end
  end

  assign total_full = eff_w * eff_h;
  assign total      = POS_W'(total_full);

  // Frame load position.
  logic [POS_W-1:0] load_pos;
  logic [POS_W-1:0] eff_pos;
  logic [POS_W:0]   pos_inc;

  assign eff_pos = cmd.load_restart ? '0 : load_pos;
  assign pos_inc = {1'b0, eff_pos} + 1'b1;
  assign status.load_done = pos_inc >= {1'b0, total};

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
    end else if (cmd.load_wr) begin
      load_pos <= status.load_done ? '0 : POS_W'(pos_inc);
    end
  end

  // Frame geometry latched when the passes start.
  logic [DIM_W-1:0] w_q, h_q;
  logic [RAD_W-1:0] r_q;
  logic [POS_W-1:0] pixels_q;
  logic             vert;
  logic [DIM_W-1:0] line_j, idx_i, idx_k;
  logic [SUM_W-1:0] sum;
  logic [VW-1:0]    src_data;

  always_ff @(posedge clk) begin
    if (cmd.latch_frame) begin
      w_q      <= eff_w;
      h_q      <= eff_h;
      r_q      <= eff_r;
      pixels_q <= total;
    end
  end

  logic [DIM_W-1:0] line_len, line_cnt;
  assign line_len = vert ? h_q : w_q;
  assign line_cnt = vert ? w_q : h_q;

  // Window limits around the current pixel.
  logic [EXT_W-1:0] i_x, r_x, ip, lm1, hi, lo, cnt_full, pre_end;
  logic [CNT_W-1:0] win_cnt;
  logic [DIM_W-1:0] add_pos, sub_pos;

  always_comb begin
    i_x      = EXT_W'(idx_i);
    r_x      = EXT_W'(r_q);
    ip       = i_x + r_x;
    lm1      = EXT_W'(line_len) - 1'b1;
    hi       = (ip < lm1) ? ip : lm1;
    lo       = (i_x > r_x) ? (i_x - r_x) : '0;
    cnt_full = hi - lo + 1'b1;
    win_cnt  = CNT_W'(cnt_full);
    add_pos  = DIM_W'(ip + 1'b1);
    sub_pos  = DIM_W'(i_x - r_x);
    pre_end  = (r_x < lm1) ? r_x : lm1;
  end

  assign status.add_ok    = ip < lm1;
  assign status.sub_ok    = i_x >= r_x;
  assign status.pre_last  = EXT_W'(idx_k) == pre_end;
  assign status.pix_last  = idx_i == line_len - 1'b1;
  assign status.line_last = line_j == line_cnt - 1'b1;
  assign status.vert_pass = vert;

  always_ff @(posedge clk) begin
    if (cmd.latch_frame) begin
      vert   <= 1'b0;
      line_j <= '0;
    end else if (cmd.next_pass) begin
      vert   <= 1'b1;
      line_j <= '0;
    end else if (cmd.next_line) begin
      line_j <= line_j + 1'b1;
    end
    if (cmd.line_init) begin
      idx_i <= '0;
      idx_k <= '0;
      sum   <= '0;
    end else begin
      if (cmd.next_pixel) idx_i <= idx_i + 1'b1;
      if (cmd.k_inc)      idx_k <= idx_k + 1'b1;
      if (cmd.pre_acc || cmd.add_acc) begin
        sum <= sum + SUM_W'(src_data);
      end else if (cmd.sub_acc) begin
        sum <= sum - SUM_W'(src_data);
      end
    end
  end

  // Store addresses are row-major in both passes; the vertical pass walks a column.
  logic [DIM_W-1:0]  rd_pos;
  logic [PROD_W-1:0] rd_prod, wr_prod;
  logic [ADDR_W-1:0] rd_addr, wr_addr;

  always_comb begin
    case (cmd.pos_sel)
      sbb_pkg::POS_ADD: rd_pos = add_pos;
      sbb_pkg::POS_SUB: rd_pos = sub_pos;
      default:          rd_pos = idx_k;
    endcase
    rd_prod = vert ? rd_pos * w_q : line_j * w_q;
    wr_prod = vert ? idx_i * w_q : line_j * w_q;
    rd_addr = ADDR_W'(rd_prod + PROD_W'(vert ? line_j : rd_pos));
    wr_addr = ADDR_W'(wr_prod + PROD_W'(vert ? line_j : idx_i));
  end

  // Frame stores.
  logic [SW-1:0] sample_store [DEPTH];
  logic [VW-1:0] row_pass_store [DEPTH];
  logic [VW-1:0] result_store [DEPTH];
  logic [SW-1:0] sample_rdata;
  logic [VW-1:0] row_rdata, res_rdata;
  logic [ADDR_W-1:0] read_pos;
  logic              last_q;
  logic [SUM_W-1:0]  quot;

  assign src_data = vert ? row_rdata : {sample_rdata, {(VW - SW){1'b0}}};

  always_ff @(posedge clk) begin
    if (cmd.load_wr && (eff_pos < total)) begin
      sample_store[ADDR_W'(eff_pos)] <= sample;
    end
    sample_rdata <= sample_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.div_store && !vert) begin
      row_pass_store[wr_addr] <= quot[VW-1:0];
    end
    row_rdata <= row_pass_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.div_store && vert) begin
      result_store[wr_addr] <= quot[VW-1:0];
    end
    res_rdata <= result_store[read_pos];
  end

  // Read-out position and result register.
  logic [POS_W-1:0] read_next;
  assign read_next = POS_W'(read_pos) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pos <= '0;
    end else if (cmd.latch_frame) begin
      read_pos <= '0;
    end else if (cmd.read_issue) begin
      read_pos <= (read_next == pixels_q) ? '0 : ADDR_W'(read_next);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_issue) last_q <= read_next == pixels_q;
    if (cmd.out_load) begin
      blurred_value <= res_rdata;
      last          <= last_q;
    end
  end

  logic div_busy;

  sbb_divider #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (sum),
    .den  (win_cnt),
    .busy (div_busy),
    .done (status.div_done),
    .quot (quot)
  );

  assert property (@(posedge clk) disable iff (rst) cmd.div_store |-> !div_busy)
    else $error("result stored while the divider is still busy");

endmodule

`default_nettype wire

// ----- rtl/core/sbb_ctrl.sv -----
`default_nettype none

module sbb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire logic              kind,
  output logic                   res_valid,
  input  wire logic              res_ready,
  input  wire sbb_pkg::status_t  status,
  output sbb_pkg::cmd_t          cmd
);

  sbb_pkg::state_t state, state_next;
  logic frame_ready, frame_ready_next;
  logic res_valid_next;
  logic req_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sbb_pkg::ST_IDLE;
      frame_ready <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      frame_ready <= frame_ready_next;
      res_valid   <= res_valid_next;
    end
  end

  assign req_fire = req_valid && req_ready;

  always_comb begin
    state_next       = state;
    frame_ready_next = frame_ready;
    res_valid_next   = res_valid && !res_ready;
    cmd              = '0;
    cmd.pos_sel      = sbb_pkg::POS_PREFILL;
    req_ready        = 1'b0;
    case (state)
      sbb_pkg::ST_IDLE: begin
        req_ready = (kind == sbb_pkg::KIND_LOAD) || !res_valid || res_ready;
        if (req_fire) begin
          if (kind == sbb_pkg::KIND_LOAD) begin
            cmd.load_wr      = 1'b1;
            cmd.load_restart = frame_ready;
            frame_ready_next = 1'b0;
            if (status.load_done) begin
              cmd.latch_frame = 1'b1;
              state_next      = sbb_pkg::ST_LINE;
            end
          end else if (frame_ready) begin
            cmd.read_issue = 1'b1;
            state_next     = sbb_pkg::ST_RESP;
          end
        end
      end
      sbb_pkg::ST_RESP: begin
        cmd.out_load   = 1'b1;
        res_valid_next = 1'b1;
        state_next     = sbb_pkg::ST_IDLE;
      end
      sbb_pkg::ST_LINE: begin
        cmd.line_init = 1'b1;
        state_next    = sbb_pkg::ST_PRE_RD;
      end
      sbb_pkg::ST_PRE_RD: begin
        state_next = sbb_pkg::ST_PRE_ACC;
      end
      sbb_pkg::ST_PRE_ACC: begin
        cmd.pre_acc = 1'b1;
        if (status.pre_last) begin
          state_next = sbb_pkg::ST_DIV_START;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = sbb_pkg::ST_PRE_RD;
        end
      end
      sbb_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = sbb_pkg::ST_DIV_WAIT;
      end
      sbb_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          if (status.add_ok) begin
            state_next = sbb_pkg::ST_ADD_RD;
          end else if (status.sub_ok) begin
            state_next = sbb_pkg::ST_SUB_RD;
          end else begin
            state_next = sbb_pkg::ST_NEXT;
          end
        end
      end
      sbb_pkg::ST_ADD_RD: begin
        cmd.pos_sel = sbb_pkg::POS_ADD;
        state_next  = sbb_pkg::ST_ADD_ACC;
      end
      sbb_pkg::ST_ADD_ACC: begin
        cmd.add_acc = 1'b1;
        state_next  = status.sub_ok ? sbb_pkg::ST_SUB_RD : sbb_pkg::ST_NEXT;
      end
      sbb_pkg::ST_SUB_RD: begin
        cmd.pos_sel = sbb_pkg::POS_SUB;
        state_next  = sbb_pkg::ST_SUB_ACC;
      end
      sbb_pkg::ST_SUB_ACC: begin
        cmd.sub_acc = 1'b1;
        state_next  = sbb_pkg::ST_NEXT;
      end
      sbb_pkg::ST_NEXT: begin
        if (!status.pix_last) begin
          cmd.next_pixel = 1'b1;
          state_next     = sbb_pkg::ST_DIV_START;
        end else if (!status.line_last) begin
          cmd.next_line = 1'b1;
          state_next    = sbb_pkg::ST_LINE;
        end else if (!status.vert_pass) begin
          cmd.next_pass = 1'b1;
          state_next    = sbb_pkg::ST_LINE;
        end else begin
          frame_ready_next = 1'b1;
          state_next       = sbb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sbb_pkg::ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    state == sbb_pkg::ST_RESP |-> !res_valid)
    else $error("result register overwritten while still full");
  assert property (@(posedge clk) disable iff (rst)
    $rose(frame_ready) |-> $past(state) == sbb_pkg::ST_NEXT)
    else $error("frame marked ready outside the end of the vertical pass");

endmodule

`default_nettype wire

// ----- dv/tb_separable_box_blur.sv -----
`timescale 1ns / 1ps

module tb_separable_box_blur;

  // Scoreboard: it keeps its own copy of the frame stores, positions and registers.
  // Each accepted request beat is replayed here. A read beat on a finished frame
  // queues the blurred pixel that the block must return.
  class blur_scoreboard;
    bit [7:0]  pix_mem[65536];
    bit [15:0] row_mem[65536];
    bit [15:0] out_mem[65536];
    int unsigned width_reg = 256, height_reg = 256, radius_reg = 1;
    int unsigned load_pos, read_pos, frame_pix;
    bit          frame_done;
    bit [15:0]   exp_value[$];
    bit          exp_last[$];
    int          errors, checked, frames;

    function int unsigned clamp_dim(int unsigned v);
      return (v < 1) ? 1 : ((v > 256) ? 256 : v);
    endfunction

    function int unsigned eff_w();
      return clamp_dim(width_reg);
    endfunction

    function int unsigned eff_h();
      return clamp_dim(height_reg);
    endfunction

    function void write_reg(logic [1:0] idx, int unsigned val);
      if (idx == sbb_pkg::CFG_WIDTH) width_reg = val & 'h1ff;
      else if (idx == sbb_pkg::CFG_HEIGHT) height_reg = val & 'h1ff;
      else if (idx == sbb_pkg::CFG_RADIUS) radius_reg = val & 'h3f;
    endfunction

    // Horizontal pass into row_mem, then vertical pass into out_mem. Each window is
    // clipped at the frame edges and divided by its own sample count.
    function void blur_frame();
      int unsigned w, h, r, lo, hi, sum;
      w = eff_w();
      h = eff_h();
      r = (radius_reg > 63) ? 63 : radius_reg;
      for (int unsigned y = 0; y < h; y++) begin
        for (int unsigned x = 0; x < w; x++) begin
          lo = (x > r) ? x - r : 0;
          hi = (x + r < w - 1) ? x + r : w - 1;
          sum = 0;
          for (int unsigned k = lo; k <= hi; k++) sum += pix_mem[y * w + k] << 8;
          row_mem[y * w + x] = sum / (hi - lo + 1);
        end
      end
      for (int unsigned x = 0; x < w; x++) begin
        for (int unsigned y = 0; y < h; y++) begin
          lo = (y > r) ? y - r : 0;
          hi = (y + r < h - 1) ? y + r : h - 1;
          sum = 0;
          for (int unsigned k = lo; k <= hi; k++) sum += row_mem[k * w + x];
          out_mem[y * w + x] = sum / (hi - lo + 1);
        end
      end
      frame_pix = w * h;
      frame_done = 1;
      read_pos = 0;
      frames++;
    endfunction

    function void note_beat(logic k, logic [7:0] s);
      int unsigned total;
      total = eff_w() * eff_h();
      if (k == sbb_pkg::KIND_LOAD) begin
        // A load on a finished frame starts a new one at pixel 0.
        if (frame_done) begin
          frame_done = 0;
          load_pos = 0;
          read_pos = 0;
        end
        if (load_pos < total) pix_mem[load_pos] = s;
        if (load_pos < 'h1ffff) load_pos++;
        if (load_pos >= total) begin
          blur_frame();
          load_pos = 0;
        end
      end else if (frame_done && frame_pix != 0) begin
        if (read_pos >= frame_pix) read_pos = 0;
        exp_value.insert(exp_value.size(), out_mem[read_pos]);
        exp_last.insert(exp_last.size(), read_pos + 1 == frame_pix);
        read_pos++;
        if (read_pos >= frame_pix) read_pos = 0;
      end
    endfunction

    function void check_result(logic [15:0] v, logic l);
      bit [15:0] ev;
      bit        el;
      if (exp_value.size() == 0) begin
        $error("result beat with nothing expected: blurred_value=%0h last=%0b", v, l);
        errors++;
        return;
      end
      ev = exp_value.pop_front();
      el = exp_last.pop_front();
      checked++;
      if (v !== ev) begin
        $error("blurred_value mismatch: expected %0h, actual %0h", ev, v);
        errors++;
      end
      if (l !== el) begin
        $error("last mismatch: expected %0b, actual %0b", el, l);
        errors++;
      end
    endfunction

    function int outstanding();
      return exp_value.size();
    endfunction
  endclass

  localparam int LIMIT = 3000000;

  logic        clk = 0;
  logic        rst = 1;
  logic        req_valid = 0;
  logic        req_ready;
  logic        kind = sbb_pkg::KIND_LOAD;
  logic [7:0]  sample = 0;
  logic        res_valid;
  logic        res_ready = 0;
  logic [15:0] blurred_value;
  logic        last;
  logic        cfg_wr_en = 0;
  logic [1:0]  cfg_index = 0;
  logic [8:0]  cfg_data = 0;

  blur_scoreboard sb = new();
  int  cycle_count;
  int  beats_sent;
  int  hold_token, hold_seen;
  bit  rx_burst, tx_burst;

  separable_box_blur dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .kind(kind), .sample(sample),
    .res_valid(res_valid), .res_ready(res_ready),
    .blurred_value(blurred_value), .last(last),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Watchdog. A run that hangs ends here as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Both monitors sample at the edge, before any nonblocking update of that step lands.
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) sb.note_beat(kind, sample);
    if (!rst && res_valid && res_ready) sb.check_result(blurred_value, last);
  end

  // Receiver. It mostly takes results at once, stalls now and then, and holds off for a
  // long stretch whenever the stimulus asks for one, so that the output register fills
  // and the block stops accepting read beats.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        res_ready <= 0;
        repeat (400) @(posedge clk);
        res_ready <= 1;
      end else if (rx_burst || $urandom_range(0, 99) < 70) begin
        res_ready <= 1;
      end else begin
        res_ready <= 0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 60)) @(posedge clk);
        else repeat ($urandom_range(0, 3)) @(posedge clk);
      end
    end
  end

  // Offers one request beat and holds it until accepted, then maybe leaves a gap.
  // Valid is only lowered in the step where the beat was taken, never raised there too.
  task automatic send_beat(logic k, logic [7:0] s);
    int gap;
    kind <= k;
    sample <= s;
    req_valid <= 1;
    do @(posedge clk); while (!req_ready);
    beats_sent++;
    gap = 0;
    if (!tx_burst && $urandom_range(0, 99) < 35)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 50) : $urandom_range(1, 3);
    if (gap > 0) begin
      req_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits for every expected result, then long enough for any filter passes still
  // running after a frame that nobody read.
  task automatic settle();
    int unsigned w, h;
    req_valid <= 0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    w = sb.eff_w();
    h = sb.eff_h();
    repeat (100 * w * h + 8 * (w + h) * 70 + 100) @(posedge clk);
  endtask

  // The request channel is idle while a register is written.
  task automatic write_cfg(logic [1:0] idx, int unsigned val);
    req_valid <= 0;
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= 9'(val);
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned r);
    write_cfg(sbb_pkg::CFG_WIDTH, w);
    write_cfg(sbb_pkg::CFG_HEIGHT, h);
    write_cfg(sbb_pkg::CFG_RADIUS, r);
  endtask

  task automatic read_beats(int n);
    for (int i = 0; i < n; i++) send_beat(sbb_pkg::KIND_READ, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_sample();
    int c;
    c = $urandom_range(0, 9);
    return (c == 0) ? 8'h00 : (c == 1) ? 8'hff : 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned w, h, r, n;
    int phase;
    bit broken;

    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: a read before any frame exists gives nothing back.
    send_beat(sbb_pkg::KIND_READ, 8'h00);
    // Pass-through on a 2x2 frame at the sample extremes; the fifth read wraps around.
    set_frame(2, 2, 0);
    send_beat(sbb_pkg::KIND_LOAD, 8'h00);
    send_beat(sbb_pkg::KIND_LOAD, 8'hff);
    send_beat(sbb_pkg::KIND_LOAD, 8'haa);
    send_beat(sbb_pkg::KIND_LOAD, 8'h55);
    read_beats(5);
    settle();
    // Widest radius on one row, with an early read that must be dropped.
    set_frame(3, 1, 63);
    send_beat(sbb_pkg::KIND_LOAD, 8'hff);
    send_beat(sbb_pkg::KIND_READ, 8'h00);
    send_beat(sbb_pkg::KIND_LOAD, 8'h00);
    send_beat(sbb_pkg::KIND_LOAD, 8'hff);
    read_beats(3);
    settle();
    // The frame shrinks under a partial load; the next load completes it. A write to
    // the unused register index must change nothing.
    set_frame(4, 2, 1);
    for (int i = 0; i < 5; i++) send_beat(sbb_pkg::KIND_LOAD, pick_sample());
    settle();
    write_cfg(sbb_pkg::CFG_WIDTH, 2);
    write_cfg(2'd3, 9'h1ff);
    send_beat(sbb_pkg::KIND_LOAD, pick_sample());
    read_beats(4);
    settle();

    // Random frames. The first two hit the size extremes: an over-range width with a
    // zero height at the widest radius, then a zero width. Each reads back six results:
    // the first pixels of the wide frame and, with a wrap, all of the five-pixel one.
    phase = 0;
    while (beats_sent < 450) begin
      case (phase)
        0: begin w = 511; h = 0; r = 63; end
        1: begin w = 0; h = 5; r = 2; end
        default: begin
          w = $urandom_range(1, 6);
          h = $urandom_range(1, 6);
          n = $urandom_range(0, 99);
          r = (n < 25) ? 0 : (n < 40) ? 63 : $urandom_range(1, 4);
        end
      endcase
      set_frame(w, h, r);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      n = sb.eff_w() * sb.eff_h();
      broken = (phase > 3) && ($urandom_range(0, 9) == 0);
      for (int i = 0; i < (broken ? (n + 1) / 2 : n); i++) begin
        if ($urandom_range(0, 9) == 0) send_beat(sbb_pkg::KIND_READ, pick_sample());
        send_beat(sbb_pkg::KIND_LOAD, pick_sample());
      end
      if (!broken) begin
        // One phase holds the receiver off while read beats keep coming.
        if (phase == 3) hold_token++;
        read_beats(phase < 2 ? 6 : n + $urandom_range(0, 3));
      end
      // The sender pauses here until every expected result has come back.
      settle();
      phase++;
    end
    tx_burst = 0;
    rx_burst = 0;

    if (sb.outstanding() != 0) begin
      $error("%0d expected results never arrived", sb.outstanding());
      sb.errors++;
    end
    $display("Covered %0d request beats over %0d blurred frames, %0d results checked.",
             beats_sent, sb.frames, sb.checked);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
